>>> rtl/core/planar_heading_angle_unit_macros.svh
// ------------------------------------------------------------------------
// planar heading angle unit assertion macros
// shared concurrent assertion forms for the checker
// ------------------------------------------------------------------------
`ifndef PLANAR_HEADING_ANGLE_UNIT_MACROS_SVH
`define PLANAR_HEADING_ANGLE_UNIT_MACROS_SVH

// same-cycle implication
`define PHA_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PHA_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pha_pkg.sv
// ------------------------------------------------------------------------
// pha_pkg
// widths, constants, angle table and stage payload type of the heading unit
// ------------------------------------------------------------------------
package pha_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int STEPS        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int FRAC_SH = 16;
	localparam int VEC_W   = DIFF_W + FRAC_SH + 3;
	localparam int ACC_W   = 26;
	localparam int HEAD_W  = 17;
	localparam int RND_W   = ACC_W - 8;

	localparam logic signed [ACC_W-1:0] DEG180_Q16   = ACC_W'(180 * 65536);
	localparam logic signed [ACC_W-1:0] DEG360_Q16   = ACC_W'(360 * 65536);
	localparam logic        [RND_W-1:0] FULL_TURN_Q8 = RND_W'(92160);
	localparam logic        [ACC_W-1:0] HALF_LSB_Q16 = ACC_W'(128);

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} vec_t;

	function automatic logic signed [ACC_W-1:0] atan_deg_q16(input int idx);
		logic signed [ACC_W-1:0] v;
		unique case (idx)
			0:       v = ACC_W'(2949120);
			1:       v = ACC_W'(1740967);
			2:       v = ACC_W'(919879);
			3:       v = ACC_W'(466945);
			4:       v = ACC_W'(234379);
			5:       v = ACC_W'(117304);
			6:       v = ACC_W'(58666);
			7:       v = ACC_W'(29335);
			8:       v = ACC_W'(14668);
			9:       v = ACC_W'(7334);
			10:      v = ACC_W'(3667);
			11:      v = ACC_W'(1833);
			12:      v = ACC_W'(917);
			13:      v = ACC_W'(458);
			14:      v = ACC_W'(229);
			15:      v = ACC_W'(115);
			16:      v = ACC_W'(57);
			17:      v = ACC_W'(29);
			18:      v = ACC_W'(14);
			19:      v = ACC_W'(7);
			20:      v = ACC_W'(4);
			21:      v = ACC_W'(2);
			22:      v = ACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/pha_front.sv
// ------------------------------------------------------------------------
// pha_front
// difference vector, zero detect and half-plane pre-rotation, two stages
// ------------------------------------------------------------------------
module pha_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	output logic                               rdy_out,
	input  logic signed [pha_pkg::COORD_W-1:0] viewer_x,
	input  logic signed [pha_pkg::COORD_W-1:0] viewer_z,
	input  logic signed [pha_pkg::COORD_W-1:0] target_x,
	input  logic signed [pha_pkg::COORD_W-1:0] target_z,
	output logic                               vld_out,
	input  logic                               rdy_in,
	output pha_pkg::vec_t                      vec_out
);

	logic signed [pha_pkg::DIFF_W-1:0] dx_s1;
	logic signed [pha_pkg::DIFF_W-1:0] dz_s1;
	logic                              vld_s1;
	pha_pkg::vec_t                     vec_s2;
	logic                              vld_s2;
	logic                              rdy_s1;
	logic                              rdy_s2;
	logic signed [pha_pkg::VEC_W-1:0]  dx_w;
	logic signed [pha_pkg::VEC_W-1:0]  dz_w;
	pha_pkg::vec_t                     vec_d;

	assign rdy_s2  = !vld_s2 || rdy_in;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign rdy_out = rdy_s1;

	assign dx_w = pha_pkg::VEC_W'(dx_s1) <<< pha_pkg::FRAC_SH;
	assign dz_w = pha_pkg::VEC_W'(dz_s1) <<< pha_pkg::FRAC_SH;

	// x = -dx; a negative x is folded into the right half plane at 180 degrees
	always_comb begin
		vec_d.zero = (dx_s1 == '0) && (dz_s1 == '0);
		if (dx_s1 > 0) begin
			vec_d.x   = dx_w;
			vec_d.y   = -dz_w;
			vec_d.acc = pha_pkg::DEG180_Q16;
		end else begin
			vec_d.x   = -dx_w;
			vec_d.y   = dz_w;
			vec_d.acc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= vld_in;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_in) begin
			dx_s1 <= pha_pkg::DIFF_W'(viewer_x) - pha_pkg::DIFF_W'(target_x);
			dz_s1 <= pha_pkg::DIFF_W'(viewer_z) - pha_pkg::DIFF_W'(target_z);
		end
		if (rdy_s2 && vld_s1) begin
			vec_s2 <= vec_d;
		end
	end

	assign vld_out = vld_s2;
	assign vec_out = vec_s2;

endmodule

>>> rtl/core/pha_cordic.sv
// ------------------------------------------------------------------------
// pha_cordic
// vectoring micro-rotations, one register stage per step
// ------------------------------------------------------------------------
module pha_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	output logic          rdy_out,
	input  pha_pkg::vec_t vec_in,
	output logic          vld_out,
	input  logic          rdy_in,
	output pha_pkg::vec_t vec_out
);

	pha_pkg::vec_t rot_vec_s [pha_pkg::STEPS];
	logic          rot_vld_s [pha_pkg::STEPS];
	logic          rdy       [pha_pkg::STEPS+1];

	assign rdy[pha_pkg::STEPS] = rdy_in;

	for (genvar k = 0; k < pha_pkg::STEPS; k++) begin : g_step
		pha_pkg::vec_t                    src;
		logic                             src_vld;
		pha_pkg::vec_t                    nxt;
		logic signed [pha_pkg::VEC_W-1:0] xs;
		logic signed [pha_pkg::VEC_W-1:0] ys;

		if (k == 0) begin : g_first
			assign src     = vec_in;
			assign src_vld = vld_in;
		end else begin : g_rest
			assign src     = rot_vec_s[k-1];
			assign src_vld = rot_vld_s[k-1];
		end

		assign rdy[k] = !rot_vld_s[k] || rdy[k+1];
		assign xs     = src.x >>> k;
		assign ys     = src.y >>> k;

		always_comb begin
			nxt.zero = src.zero;
			if (!src.y[pha_pkg::VEC_W-1]) begin
				nxt.x   = src.x + ys;
				nxt.y   = src.y - xs;
				nxt.acc = src.acc + pha_pkg::atan_deg_q16(k);
			end else begin
				nxt.x   = src.x - ys;
				nxt.y   = src.y + xs;
				nxt.acc = src.acc - pha_pkg::atan_deg_q16(k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				rot_vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_vld) begin
				rot_vec_s[k] <= nxt;
			end
		end
	end

	assign rdy_out = rdy[0];
	assign vld_out = rot_vld_s[pha_pkg::STEPS-1];
	assign vec_out = rot_vec_s[pha_pkg::STEPS-1];

endmodule

>>> rtl/core/pha_back.sv
// ------------------------------------------------------------------------
// pha_back
// angle wrap, rounding to 8 fractional bits and the output register
// ------------------------------------------------------------------------
module pha_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld_in,
	output logic                             rdy_out,
	input  pha_pkg::vec_t                    vec_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pha_pkg::HEAD_W-1:0]       heading_deg,
	output logic                             zero_vector
);

	logic [pha_pkg::ACC_W-1:0]  acc_s1;
	logic                       zero_s1;
	logic                       vld_s1;
	logic [pha_pkg::HEAD_W-1:0] head_s2;
	logic                       zero_s2;
	logic                       vld_s2;
	logic                       rdy_s1;
	logic                       rdy_s2;
	logic [pha_pkg::ACC_W-1:0]  acc_wrap;
	logic [pha_pkg::ACC_W-1:0]  acc_rnd;
	logic [pha_pkg::RND_W-1:0]  head_rnd;
	logic [pha_pkg::HEAD_W-1:0] head_d;

	assign rdy_s2  = !vld_s2 || !out_stall;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign rdy_out = rdy_s1;

	assign acc_wrap = vec_in.acc[pha_pkg::ACC_W-1] ?
		pha_pkg::ACC_W'(vec_in.acc + pha_pkg::DEG360_Q16) : pha_pkg::ACC_W'(vec_in.acc);

	assign acc_rnd  = acc_s1 + pha_pkg::HALF_LSB_Q16;
	assign head_rnd = acc_rnd[pha_pkg::ACC_W-1:8];

	// rounding up to a full turn wraps to zero
	always_comb begin
		if (zero_s1) begin
			head_d = '0;
		end else if (head_rnd >= pha_pkg::FULL_TURN_Q8) begin
			head_d = pha_pkg::HEAD_W'(head_rnd - pha_pkg::FULL_TURN_Q8);
		end else begin
			head_d = pha_pkg::HEAD_W'(head_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= vld_in;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_in) begin
			acc_s1  <= acc_wrap;
			zero_s1 <= vec_in.zero;
		end
		if (rdy_s2 && vld_s1) begin
			head_s2 <= head_d;
			zero_s2 <= zero_s1;
		end
	end

	assign out_valid   = vld_s2;
	assign heading_deg = head_s2;
	assign zero_vector = zero_s2;

endmodule

>>> rtl/core/planar_heading_angle_unit.sv
// ------------------------------------------------------------------------
// planar_heading_angle_unit
// heading in degrees of the viewer-minus-target vector in the x/z plane
// ------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns its heading, 0
// up to 360 degrees from the -x axis with 8 fractional bits. The front stages
// form the difference and fold it into the right half plane, a register stage
// for each CORDIC micro-rotation follows, and the back stages wrap and round. Every
// stage holds its own valid bit, so bubbles close up under output stall and
// new words keep entering until the pipeline is full. Coincident positions
// give heading 0 with zero_vector set.
module planar_heading_angle_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [pha_pkg::COORD_W-1:0] viewer_x,
	input  logic signed [pha_pkg::COORD_W-1:0] viewer_z,
	input  logic signed [pha_pkg::COORD_W-1:0] target_x,
	input  logic signed [pha_pkg::COORD_W-1:0] target_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pha_pkg::HEAD_W-1:0]         heading_deg,
	output logic                               zero_vector
);

	logic          front_rdy;
	logic          front_vld;
	pha_pkg::vec_t front_vec;
	logic          rot_rdy;
	logic          rot_vld;
	pha_pkg::vec_t rot_vec;
	logic          back_rdy;

	assign in_stall = !front_rdy;

	pha_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (in_valid),
		.rdy_out  (front_rdy),
		.viewer_x (viewer_x),
		.viewer_z (viewer_z),
		.target_x (target_x),
		.target_z (target_z),
		.vld_out  (front_vld),
		.rdy_in   (rot_rdy),
		.vec_out  (front_vec)
	);

	pha_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (front_vld),
		.rdy_out (rot_rdy),
		.vec_in  (front_vec),
		.vld_out (rot_vld),
		.rdy_in  (back_rdy),
		.vec_out (rot_vec)
	);

	pha_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_in      (rot_vld),
		.rdy_out     (back_rdy),
		.vec_in      (rot_vec),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heading_deg (heading_deg),
		.zero_vector (zero_vector)
	);

endmodule

>>> rtl/core/pha_checker.sv
// ------------------------------------------------------------------------
// pha_checker
// port-level checks of the heading unit, bound to the top level
// ------------------------------------------------------------------------
`include "planar_heading_angle_unit_macros.svh"

module pha_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic signed [pha_pkg::COORD_W-1:0] viewer_x,
	input logic signed [pha_pkg::COORD_W-1:0] viewer_z,
	input logic signed [pha_pkg::COORD_W-1:0] target_x,
	input logic signed [pha_pkg::COORD_W-1:0] target_z,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pha_pkg::HEAD_W-1:0]         heading_deg,
	input logic                               zero_vector
);

	// a stalled result word holds
	`PHA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(heading_deg) && $stable(zero_vector), "stalled result word changed")

	// heading stays below a full turn
	`PHA_ASSERT_NOW(a_head_range, clk, arst_n, out_valid, heading_deg < pha_pkg::HEAD_W'(92160), "heading out of range")

	// a coincident pair reports zero heading
	`PHA_ASSERT_NOW(a_zero_head, clk, arst_n, out_valid && zero_vector, heading_deg == '0, "zero vector with nonzero heading")

	// with an empty output the pipeline never refuses a word
	`PHA_ASSERT_NEXT(a_in_free, clk, arst_n, !out_valid && !in_valid, !in_stall, "input stalled with nothing pending")

endmodule

bind planar_heading_angle_unit pha_checker u_pha_checker (.*);

>>> dv/tb_planar_heading_angle_unit.sv
// ------------------------------------------------------------------------
// tb_planar_heading_angle_unit
// self-checking bench for the x/z plane heading unit
// ------------------------------------------------------------------------
// Drives viewer and target positions through the valid/stall input port and
// predicts each heading with a bit-exact vectoring cordic of its own. Every
// returned word is compared with the oldest prediction. A directed set covers
// axes, diagonals, coordinate extremes, coincident positions and the wrap from
// 360 back to 0. A random set follows. Both sides pause at random, and one
// long receiver hold-off fills the pipeline so that the input stalls.
module tb_planar_heading_angle_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS    = 750;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DRAIN_CYCLES    = 2 + pha_pkg::STEPS + 2 + 12;
	localparam int MAX_STEPS       = 24;

	typedef logic signed [pha_pkg::COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [pha_pkg::HEAD_W-1:0] heading;
		logic                       zero;
	} heading_word_t;

	localparam coord_t CMAX = 24'sh7FFFFF;
	localparam coord_t CMIN = 24'sh800000;

	localparam longint DEG180_Q16 = 64'sd180 * 64'sd65536;
	localparam longint DEG360_Q16 = 64'sd360 * 64'sd65536;
	localparam longint TURN_Q8    = 64'sd92160;

	localparam longint ATAN_DEG_Q16 [MAX_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	class heading_checker;
		heading_word_t pending_headings[$];
		int            mismatches;

		function new();
			mismatches = 0;
		endfunction

		function heading_word_t cordic_heading(input coord_t vx, vz, tx, tz);
			longint        dx, dz, x, y, xs, ys, acc, h;
			int            steps;
			heading_word_t w;
			dx = longint'(vx) - longint'(tx);
			dz = longint'(vz) - longint'(tz);
			w  = '0;
			if (dx == 0 && dz == 0) begin
				w.zero = 1'b1;
				return w;
			end
			x   = -dx * 65536;
			y   = dz * 65536;
			acc = 0;
			if (x < 0) begin
				x   = -x;
				y   = -y;
				acc = DEG180_Q16;
			end
			steps = (pha_pkg::CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : pha_pkg::CORDIC_STEPS;
			for (int i = 0; i < steps; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x   = x + ys;
					y   = y - xs;
					acc = acc + ATAN_DEG_Q16[i];
				end else begin
					x   = x - ys;
					y   = y + xs;
					acc = acc - ATAN_DEG_Q16[i];
				end
			end
			if (acc < 0)
				acc = acc + DEG360_Q16;
			h = (acc + 128) >>> 8;
			if (h >= TURN_Q8)
				h = h - TURN_Q8;
			w.heading = h[pha_pkg::HEAD_W-1:0];
			return w;
		endfunction

		function void note_position(input coord_t vx, vz, tx, tz);
			pending_headings.insert(pending_headings.size(), cordic_heading(vx, vz, tx, tz));
		endfunction

		function void check_heading(input logic [pha_pkg::HEAD_W-1:0] heading,
				input logic zero);
			heading_word_t w;
			if (pending_headings.size() == 0) begin
				$error("unexpected word: heading_deg %0d zero_vector %0b", heading, zero);
				mismatches++;
				return;
			end
			w = pending_headings.pop_front();
			if (heading !== w.heading) begin
				$error("heading_deg expected %0d actual %0d", w.heading, heading);
				mismatches++;
			end
			if (zero !== w.zero) begin
				$error("zero_vector expected %0b actual %0b", w.zero, zero);
				mismatches++;
			end
		endfunction

		function int pending_count();
			return pending_headings.size();
		endfunction
	endclass

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	coord_t                     viewer_x  = '0;
	coord_t                     viewer_z  = '0;
	coord_t                     target_x  = '0;
	coord_t                     target_z  = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [pha_pkg::HEAD_W-1:0] heading_deg;
	logic                       zero_vector;

	heading_checker board = new();
	int             words_out   = 0;
	int             idle_cycles = 0;

	planar_heading_angle_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.viewer_x    (viewer_x),
		.viewer_z    (viewer_z),
		.target_x    (target_x),
		.target_z    (target_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.heading_deg (heading_deg),
		.zero_vector (zero_vector)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic coord_t corner_value();
		case ($urandom_range(0, 4))
			0:       return CMAX;
			1:       return CMIN;
			2:       return 1;
			3:       return -1;
			default: return 0;
		endcase
	endfunction

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic send_position(input coord_t vx, vz, tx, tz);
		@(negedge clk);
		in_valid <= 1'b1;
		viewer_x <= vx;
		viewer_z <= vz;
		target_x <= tx;
		target_z <= tz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_position(vx, vz, tx, tz);
	endtask

	task automatic send_after_gap(input coord_t vx, vz, tx, tz);
		pause_sender(pick_gap());
		send_position(vx, vz, tx, tz);
	endtask

	task automatic random_position(output coord_t vx, vz, tx, tz);
		coord_t d;
		tx = coord_t'($urandom());
		tz = coord_t'($urandom());
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				vx = coord_t'($urandom());
				vz = coord_t'($urandom());
			end
			4, 5: begin
				vx = tx + coord_t'($urandom_range(0, 512) - 256);
				vz = tz + coord_t'($urandom_range(0, 512) - 256);
			end
			6: begin
				vx = coord_t'($urandom());
				vz = coord_t'($urandom());
				if ($urandom_range(0, 1))
					vx = tx;
				else
					vz = tz;
			end
			7: begin
				vx = tx;
				vz = tz;
			end
			8: begin
				d  = coord_t'($urandom_range(1, 4000));
				vx = $urandom_range(0, 1) ? tx + d : tx - d;
				vz = $urandom_range(0, 1) ? tz + d : tz - d;
			end
			default: begin
				vx = corner_value();
				vz = corner_value();
				tx = corner_value();
				tz = corner_value();
			end
		endcase
	endtask

	// every result word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_heading(heading_deg, zero_vector);
			words_out++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, free stretches and one long hold-off
	initial begin
		bit held;
		int run;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && words_out >= 60) begin
				held = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			repeat (pick_gap()) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	initial begin
		coord_t vx, vz, tx, tz;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		send_after_gap(0, 0, 0, 0);
		send_after_gap(CMAX, CMIN, CMAX, CMIN);
		send_after_gap(-1, -1, -1, -1);
		send_after_gap(CMAX, 0, CMIN, 0);
		send_after_gap(CMIN, 0, CMAX, 0);
		send_after_gap(0, CMAX, 0, CMIN);
		send_after_gap(0, CMIN, 0, CMAX);
		send_after_gap(CMAX, CMAX, CMIN, CMIN);
		send_after_gap(CMIN, CMIN, CMAX, CMAX);
		send_after_gap(CMIN, CMAX, CMAX, CMIN);
		send_after_gap(CMAX, CMIN, CMIN, CMAX);
		// just below a full turn, rounds back to zero
		send_after_gap(CMIN, -1, CMAX, 0);
		send_after_gap(CMIN, 1, CMAX, 0);
		send_after_gap(CMAX, -1, CMIN, 0);
		send_after_gap(1, 0, 0, 0);
		send_after_gap(-1, 0, 0, 0);
		send_after_gap(0, 1, 0, 0);
		send_after_gap(0, -1, 0, 0);
		send_after_gap(1, 1, 0, 0);
		send_after_gap(-1, -1, 0, 0);
		send_after_gap(0, 0, CMIN, CMIN);
		send_after_gap(CMAX, 1, CMAX, 0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			random_position(vx, vz, tx, tz);
			if ((i / 50) % 4 != 3)
				pause_sender(pick_gap());
			send_position(vx, vz, tx, tz);
		end
		pause_sender(1);

		while (board.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending_count() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
